@@ rtl/led_matrix_scan_driver_top_defines.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the LED matrix scan driver
// Each macro expects clk_i and rst_ni to be visible where it is used.
// -----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_DRIVER_TOP_DEFINES_SVH
`define LED_MATRIX_SCAN_DRIVER_TOP_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define LMSD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define LMSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent starts in the cycle after the antecedent.
`define LMSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lmsd_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix scan driver package
// Shared constants, codes and transaction payload types.
// -----------------------------------------------------------------------------
package lmsd_pkg;

  localparam int PANEL_COLUMNS_DEF = 32;
  localparam int HALF_ROWS_DEF     = 16;
  localparam int FRAME_COUNT_DEF   = 8;

  // Number of distinct pixel levels, fixed by the 5-bit level field.
  localparam int LEVELS = 32;

  localparam int LEVEL_W    = 5;
  localparam int COORD_W    = 5;
  localparam int SLOT_W     = 3;
  localparam int COLOR_W    = 3;
  localparam int ROW_SEL_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [1:0] {
    ACT_WRITE_PIXEL = 2'd0,
    ACT_WRITE_TABLE = 2'd1,
    ACT_SCAN_TICK   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    PH_DATA     = 3'd0,
    PH_CLOCK    = 3'd1,
    PH_OE_HIGH  = 3'd2,
    PH_LAT_HIGH = 3'd3,
    PH_LAT_LOW  = 3'd4,
    PH_ROW      = 3'd5
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLANK         = 1'b0,
    CFG_FRAMES_IN_USE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e              action;
    logic [COORD_W-1:0]   pixel_row;
    logic [COORD_W-1:0]   pixel_column;
    logic [LEVEL_W-1:0]   level;
    logic [SLOT_W-1:0]    frame_slot;
    logic [COLOR_W-1:0]   color;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0]   rgb_top;
    logic [COLOR_W-1:0]   rgb_bottom;
    logic                 shift_clock;
    logic                 latch;
    logic                 output_disable;
    logic [ROW_SEL_W-1:0] row_select;
    logic                 frame_end;
  } out_item_t;

  // Panel control pins that persist from one tick to the next.
  typedef struct packed {
    logic                 shift_clock;
    logic                 latch;
    logic                 output_disable;
    logic [ROW_SEL_W-1:0] row_select;
  } ctrl_pins_t;

endpackage

@@ rtl/lmsd_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix scan driver stream interfaces
// Valid/ready channels for command items and for panel pin results.
// -----------------------------------------------------------------------------
interface lmsd_in_if;
  logic               valid;
  logic               ready;
  lmsd_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lmsd_out_if;
  logic                valid;
  logic                ready;
  lmsd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/lmsd_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data (read-first).
// -----------------------------------------------------------------------------
module lmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/led_matrix_scan_driver_top.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix scan driver
// Pixel level store, level-by-frame intensity table and HUB75-style scan.
// -----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  in_i      sink       pixel write, table write or scan tick
//  out_o     source     panel pin state, one per scan tick
//  cfg       write      blank (index 0), frames_in_use (index 1)
//
// One item is accepted per cycle while in_i.ready is high. A scan tick reads
// the two pixel half-stores, then the two intensity table copies; its result
// passes the stage 1 and stage 2 registers, then enters a four-entry result queue.
// After reset a clearing pass zeroes all stores, one address per cycle, over
// max(HALF_ROWS*PANEL_COLUMNS, 32*FRAME_COUNT) addresses (512 at the defaults).
// in_i.ready falls while the queue and the two read stages hold four results.

`include "led_matrix_scan_driver_top_defines.svh"

module led_matrix_scan_driver_top #(
  parameter int PANEL_COLUMNS = lmsd_pkg::PANEL_COLUMNS_DEF,
  parameter int HALF_ROWS     = lmsd_pkg::HALF_ROWS_DEF,
  parameter int FRAME_COUNT   = lmsd_pkg::FRAME_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lmsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lmsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  lmsd_in_if.sink                         in_i,
  lmsd_out_if.source                      out_o
);

  localparam int COL_W      = $clog2(PANEL_COLUMNS);
  localparam int ROW_W      = $clog2(HALF_ROWS);
  localparam int FRAME_W    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int PIX_DEPTH  = HALF_ROWS * PANEL_COLUMNS;
  localparam int PIX_AW     = $clog2(PIX_DEPTH);
  localparam int TAB_DEPTH  = lmsd_pkg::LEVELS * FRAME_COUNT;
  localparam int TAB_AW     = $clog2(TAB_DEPTH);
  localparam int CLR_DEPTH  = (PIX_DEPTH > TAB_DEPTH) ? PIX_DEPTH : TAB_DEPTH;
  localparam int CLR_W      = $clog2(CLR_DEPTH);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 3);

  typedef struct packed {
    lmsd_pkg::ctrl_pins_t ctrl;
    logic                 frame_end;
    logic                 is_data;
    logic                 blank;
    logic [FRAME_W-1:0]   frame;
  } tick_t;

  // Configuration registers.
  logic       blank_q;
  logic [3:0] frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q  <= 1'b1;
      frames_q <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmsd_pkg::CFG_BLANK:         blank_q  <= cfg_wdata_i[0];
        lmsd_pkg::CFG_FRAMES_IN_USE: frames_q <= cfg_wdata_i;
      endcase
    end
  end

  // Clearing pass over all stores after reset.
  logic             clr_busy_q;
  logic [CLR_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Input handshake.
  logic                   accept;
  logic                   tick_acc;
  lmsd_pkg::in_item_t     item;
  logic                   s1_v_q;
  logic                   s2_v_q;
  logic [FIFO_CW-1:0]     fifo_cnt_q;
  logic [FIFO_CW-1:0]     occupancy;

  assign item      = in_i.payload;
  assign occupancy = fifo_cnt_q + FIFO_CW'(s1_v_q) + FIFO_CW'(s2_v_q);
  assign in_i.ready = !clr_busy_q && (occupancy < FIFO_CW'(FIFO_DEPTH));
  assign accept    = in_i.valid && in_i.ready;
  assign tick_acc  = accept && (item.action == lmsd_pkg::ACT_SCAN_TICK);

  // Scan state.
  lmsd_pkg::phase_e     phase_q, phase_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  lmsd_pkg::ctrl_pins_t ctrl_q, ctrl_d;
  logic                 frame_end_d;
  logic                 is_data_d;
  logic                 last_col;
  logic                 last_row;
  logic [4:0]           frame_limit;
  logic [4:0]           frame_inc;

  assign last_col  = (col_q == COL_W'(PANEL_COLUMNS - 1));
  assign last_row  = (row_q == ROW_W'(HALF_ROWS - 1));
  assign frame_inc = 5'(frame_q) + 5'd1;

  // Zero acts as one and anything above the table's frame count saturates.
  always_comb begin
    if (frames_q == 4'd0) begin
      frame_limit = 5'd1;
    end else if (5'(frames_q) > 5'(FRAME_COUNT)) begin
      frame_limit = 5'(FRAME_COUNT);
    end else begin
      frame_limit = 5'(frames_q);
    end
  end

  // Next state of the scan sequencer.
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    frame_d = frame_q;
    if (tick_acc) begin
      unique case (phase_q)
        lmsd_pkg::PH_DATA: phase_d = lmsd_pkg::PH_CLOCK;
        lmsd_pkg::PH_CLOCK: begin
          if (last_col) begin
            col_d   = '0;
            phase_d = lmsd_pkg::PH_OE_HIGH;
          end else begin
            col_d   = col_q + 1'b1;
            phase_d = lmsd_pkg::PH_DATA;
          end
        end
        lmsd_pkg::PH_OE_HIGH:  phase_d = lmsd_pkg::PH_LAT_HIGH;
        lmsd_pkg::PH_LAT_HIGH: phase_d = lmsd_pkg::PH_LAT_LOW;
        lmsd_pkg::PH_LAT_LOW:  phase_d = lmsd_pkg::PH_ROW;
        lmsd_pkg::PH_ROW: begin
          phase_d = lmsd_pkg::PH_DATA;
          if (last_row) begin
            row_d   = '0;
            frame_d = (frame_inc >= frame_limit) ? '0 : FRAME_W'(frame_inc);
          end else begin
            row_d = row_q + 1'b1;
          end
        end
        default: phase_d = lmsd_pkg::PH_DATA;
      endcase
    end
  end

  // Control pin outputs of the scan sequencer.
  always_comb begin
    ctrl_d      = ctrl_q;
    frame_end_d = 1'b0;
    is_data_d   = 1'b0;
    if (tick_acc) begin
      unique case (phase_q)
        lmsd_pkg::PH_DATA: begin
          ctrl_d.shift_clock = 1'b0;
          is_data_d          = 1'b1;
        end
        lmsd_pkg::PH_CLOCK: ctrl_d.shift_clock = 1'b1;
        lmsd_pkg::PH_OE_HIGH: begin
          ctrl_d.shift_clock    = 1'b0;
          ctrl_d.output_disable = 1'b1;
        end
        lmsd_pkg::PH_LAT_HIGH: ctrl_d.latch = 1'b1;
        lmsd_pkg::PH_LAT_LOW:  ctrl_d.latch = 1'b0;
        lmsd_pkg::PH_ROW: begin
          ctrl_d.output_disable = 1'b0;
          ctrl_d.row_select     = lmsd_pkg::ROW_SEL_W'(row_q);
          frame_end_d           = last_row;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lmsd_pkg::PH_DATA;
      col_q   <= '0;
      row_q   <= '0;
      frame_q <= '0;
      ctrl_q  <= '0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      frame_q <= frame_d;
      ctrl_q  <= ctrl_d;
    end
  end

  // Pixel store, split into top and bottom halves so a tick reads both at once.
  logic              wr_in_range;
  logic              wr_top;
  logic [5:0]        wr_row_half;
  logic [PIX_AW-1:0] wr_pix_addr;
  logic [PIX_AW-1:0] rd_pix_addr;
  logic              pix_wr;
  logic              pix_top_we, pix_bot_we;
  logic [PIX_AW-1:0] pix_waddr;
  logic [lmsd_pkg::LEVEL_W-1:0] pix_wdata;
  logic [lmsd_pkg::LEVEL_W-1:0] pix_top_rdata, pix_bot_rdata;

  assign wr_in_range = (32'(item.pixel_row) < 2 * HALF_ROWS) &&
                       (32'(item.pixel_column) < PANEL_COLUMNS);
  assign wr_top      = (32'(item.pixel_row) < HALF_ROWS);
  assign wr_row_half = wr_top ? 6'(item.pixel_row) : 6'(item.pixel_row) - 6'(HALF_ROWS);
  assign wr_pix_addr = PIX_AW'(wr_row_half) * PIX_AW'(PANEL_COLUMNS) +
                       PIX_AW'(item.pixel_column);
  assign rd_pix_addr = PIX_AW'(row_q) * PIX_AW'(PANEL_COLUMNS) + PIX_AW'(col_q);
  assign pix_wr      = accept && (item.action == lmsd_pkg::ACT_WRITE_PIXEL) && wr_in_range;

  always_comb begin
    if (clr_busy_q) begin
      pix_top_we = (32'(clr_cnt_q) < PIX_DEPTH);
      pix_bot_we = pix_top_we;
      pix_waddr  = PIX_AW'(clr_cnt_q);
      pix_wdata  = '0;
    end else begin
      pix_top_we = pix_wr && wr_top;
      pix_bot_we = pix_wr && !wr_top;
      pix_waddr  = wr_pix_addr;
      pix_wdata  = item.level;
    end
  end

  lmsd_ram #(.WIDTH(lmsd_pkg::LEVEL_W), .DEPTH(PIX_DEPTH)) u_pix_top (
    .clk_i   (clk_i),
    .we_i    (pix_top_we),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .raddr_i (rd_pix_addr),
    .rdata_o (pix_top_rdata)
  );

  lmsd_ram #(.WIDTH(lmsd_pkg::LEVEL_W), .DEPTH(PIX_DEPTH)) u_pix_bot (
    .clk_i   (clk_i),
    .we_i    (pix_bot_we),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .raddr_i (rd_pix_addr),
    .rdata_o (pix_bot_rdata)
  );

  // Stage 1: pixel levels are back; look up both colours.
  tick_t s1_q, s1_d;

  assign s1_d = '{ctrl: ctrl_d, frame_end: frame_end_d, is_data: is_data_d,
                  blank: blank_q, frame: frame_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= tick_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Intensity table, held twice so the top and bottom lookups run in parallel.
  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr;
  logic [lmsd_pkg::COLOR_W-1:0] tab_wdata;
  logic [TAB_AW-1:0] tab_top_raddr, tab_bot_raddr;
  logic [lmsd_pkg::COLOR_W-1:0] tab_top_rdata, tab_bot_rdata;

  always_comb begin
    if (clr_busy_q) begin
      tab_we    = (32'(clr_cnt_q) < TAB_DEPTH);
      tab_waddr = TAB_AW'(clr_cnt_q);
      tab_wdata = '0;
    end else begin
      tab_we    = accept && (item.action == lmsd_pkg::ACT_WRITE_TABLE) &&
                  (32'(item.frame_slot) < FRAME_COUNT);
      tab_waddr = TAB_AW'(item.level) * TAB_AW'(FRAME_COUNT) + TAB_AW'(item.frame_slot);
      tab_wdata = item.color;
    end
  end

  assign tab_top_raddr = TAB_AW'(pix_top_rdata) * TAB_AW'(FRAME_COUNT) + TAB_AW'(s1_q.frame);
  assign tab_bot_raddr = TAB_AW'(pix_bot_rdata) * TAB_AW'(FRAME_COUNT) + TAB_AW'(s1_q.frame);

  lmsd_ram #(.WIDTH(lmsd_pkg::COLOR_W), .DEPTH(TAB_DEPTH)) u_tab_top (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_top_raddr),
    .rdata_o (tab_top_rdata)
  );

  lmsd_ram #(.WIDTH(lmsd_pkg::COLOR_W), .DEPTH(TAB_DEPTH)) u_tab_bot (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_bot_raddr),
    .rdata_o (tab_bot_rdata)
  );

  // Stage 2: colours are back; colour pins keep their level outside data ticks.
  tick_t                        s2_q;
  logic [lmsd_pkg::COLOR_W-1:0] color_top_q, color_top_d;
  logic [lmsd_pkg::COLOR_W-1:0] color_bot_q, color_bot_d;
  lmsd_pkg::out_item_t          push_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s1_q;
  end

  always_comb begin
    color_top_d = color_top_q;
    color_bot_d = color_bot_q;
    if (s2_q.is_data) begin
      color_top_d = s2_q.blank ? '0 : tab_top_rdata;
      color_bot_d = s2_q.blank ? '0 : tab_bot_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_top_q <= '0;
      color_bot_q <= '0;
    end else if (s2_v_q) begin
      color_top_q <= color_top_d;
      color_bot_q <= color_bot_d;
    end
  end

  assign push_item = '{rgb_top:        color_top_d,
                       rgb_bottom:     color_bot_d,
                       shift_clock:    s2_q.ctrl.shift_clock,
                       latch:          s2_q.ctrl.latch,
                       output_disable: s2_q.ctrl.output_disable,
                       row_select:     s2_q.ctrl.row_select,
                       frame_end:      s2_q.frame_end};

  // Result queue; the credit check on in_i.ready keeps it from overflowing.
  lmsd_pkg::out_item_t fifo_mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic                pop;

  assign pop           = out_o.valid && out_o.ready;
  assign out_o.valid   = (fifo_cnt_q != '0);
  assign out_o.payload = fifo_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      fifo_mem_q[wr_ptr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (s2_v_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (s2_v_q && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + 1'b1;
      end else if (!s2_v_q && pop) begin
        fifo_cnt_q <= fifo_cnt_q - 1'b1;
      end
    end
  end

  `LMSD_ASSERT(a_no_overflow, occupancy <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
  `LMSD_ASSERT(a_frame_range, 32'(frame_q) < FRAME_COUNT, "frame index out of range")
  `LMSD_ASSERT_NXT(a_row_end, tick_acc && phase_q == lmsd_pkg::PH_CLOCK && last_col, phase_q == lmsd_pkg::PH_OE_HIGH && col_q == '0, "row end sequence not entered")
  `LMSD_ASSERT_NXT(a_tick_latency, tick_acc, s1_v_q ##1 s2_v_q, "tick lost in read stages")

endmodule
